FILE: rtl/core/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiator package
// Widths, reset values and the request/response bundles shared between the
// sequencer and the modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package modexp_pkg;

  localparam int unsigned OpWidth  = 31;
  localparam int unsigned ExpWidth = 63;
  // One multiplier bit is consumed per step.
  localparam int unsigned MulSteps = OpWidth;
  localparam int unsigned CntWidth = $clog2(MulSteps);

  localparam logic [OpWidth-1:0] ModulusReset = 31'd1000000007;

  // Request into the modular multiplier: a registered start pulse plus operands.
  // op_a must already be below the modulus; op_b may be any 31-bit value.
  typedef struct packed {
    logic               start;
    logic [OpWidth-1:0] op_a;
    logic [OpWidth-1:0] op_b;
  } mul_req_t;

  // Response: done pulses for one cycle while product holds op_a * op_b mod m.
  typedef struct packed {
    logic               done;
    logic [OpWidth-1:0] product;
  } mul_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/modular_exponentiator.sv
// Sequence per beat: the shared unit first reduces the base, then for each
//   exponent bit, lowest first, it multiplies when the bit is set and squares
//   the base, the square after the top set bit being skipped.
// Throughput: one beat at a time; in_ready_o is low from acceptance until the
//   result is moved into the output register.
// Reset: asynchronous, active low; the modulus returns to 1000000007.
// ----------------------------------------------------------------------------
// Modular exponentiator
// Computes base^exponent mod modulus by right-to-left square-and-multiply,
// with an optional Fermat-inverse mode that uses modulus - 2 as exponent.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiator (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration: the modulus register.
  input  wire logic                                cfg_we_i,
  input  wire logic [modexp_pkg::OpWidth-1:0]      cfg_wdata_i,
  // Input channel.
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [modexp_pkg::OpWidth-1:0]      base_value_i,
  input  wire logic [modexp_pkg::ExpWidth-1:0]     exponent_i,
  input  wire logic                                invert_i,
  // Output channel.
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [modexp_pkg::OpWidth-1:0]           power_result_o
);

  // Sequencer states. The three multiply states issue a request to the shared
  // unit on entry and wait there for its done pulse.
  typedef enum logic [2:0] {
    StIdle,
    StReduce,
    StDecide,
    StMul,
    StSqr,
    StFinish
  } state_e;

  state_e                               state_q;
  logic [modexp_pkg::OpWidth-1:0]       mod_q;
  logic [modexp_pkg::OpWidth-1:0]       acc_q;
  logic [modexp_pkg::OpWidth-1:0]       base_q;
  logic [modexp_pkg::ExpWidth-1:0]      exp_q;
  logic                                 out_valid_q;
  logic [modexp_pkg::OpWidth-1:0]       result_q;
  modexp_pkg::mul_req_t                 req_q;
  modexp_pkg::mul_rsp_t                 rsp;

  logic                                 in_beat;
  logic                                 out_free;
  logic [modexp_pkg::OpWidth-1:0]       mod_minus2;

  assign in_ready_o     = (state_q == StIdle);
  assign in_beat        = in_valid_i && in_ready_o;
  // The output register may be loaded when empty or when its beat leaves now.
  assign out_free       = !out_valid_q || out_ready_i;
  assign mod_minus2     = mod_q - 31'd2;
  assign out_valid_o    = out_valid_q;
  assign power_result_o = result_q;

  // The modulus must only be changed while the block is idle; the block itself
  // does not enforce this. The multiplier reads it straight from this register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= modexp_pkg::ModulusReset;
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      result_q    <= '0;
      acc_q       <= '0;
      base_q      <= '0;
      exp_q       <= '0;
      req_q       <= '0;
    end else begin
      // A finished value enters the output register when it is empty or as the old beat leaves.
      if ((state_q == StFinish) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // The start flag is high only in the cycle after a request is issued,
      // and that cycle is always spent in one of the waiting states.
      unique case (state_q)
        StIdle: begin
          if (in_beat) begin
            base_q <= base_value_i;
            exp_q  <= invert_i
                    ? {{(modexp_pkg::ExpWidth - modexp_pkg::OpWidth){1'b0}}, mod_minus2}
                    : exponent_i;
            if (mod_q < 31'd2) begin
              // A modulus below two has no residues to reduce into: answer zero.
              acc_q   <= '0;
              state_q <= StFinish;
            end else begin
              // First pass of the unit reduces the base: 1 * base mod m.
              acc_q   <= 31'd1;
              req_q   <= '{start: 1'b1, op_a: 31'd1, op_b: base_value_i};
              state_q <= StReduce;
            end
          end
        end

        StReduce: begin
          req_q.start <= 1'b0;
          if (rsp.done) begin
            base_q  <= rsp.product;
            state_q <= StDecide;
          end
        end

        StDecide: begin
          // Accumulator starts at one, so a zero exponent finishes with one.
          if (exp_q == '0) begin
            state_q <= StFinish;
          end else if (exp_q[0]) begin
            req_q   <= '{start: 1'b1, op_a: acc_q, op_b: base_q};
            state_q <= StMul;
          end else begin
            req_q   <= '{start: 1'b1, op_a: base_q, op_b: base_q};
            state_q <= StSqr;
          end
        end

        StMul: begin
          if (rsp.done) begin
            acc_q <= rsp.product;
            // The square after the top exponent bit would never be used.
            if (exp_q[modexp_pkg::ExpWidth-1:1] == '0) begin
              req_q.start <= 1'b0;
              state_q     <= StFinish;
            end else begin
              req_q   <= '{start: 1'b1, op_a: base_q, op_b: base_q};
              state_q <= StSqr;
            end
          end else begin
            req_q.start <= 1'b0;
          end
        end

        StSqr: begin
          req_q.start <= 1'b0;
          if (rsp.done) begin
            base_q  <= rsp.product;
            exp_q   <= {1'b0, exp_q[modexp_pkg::ExpWidth-1:1]};
            state_q <= StDecide;
          end
        end

        StFinish: begin
          // Hold the finished value until the output register has room.
          if (out_free) begin
            result_q <= acc_q;
            state_q  <= StIdle;
          end
        end

        default: begin
          req_q.start <= 1'b0;
          state_q     <= StIdle;
        end
      endcase
    end
  end

  modexp_mulmod u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .modulus_i (mod_q),
    .req_i     (req_q),
    .rsp_o     (rsp)
  );

endmodule

`default_nettype wire

FILE: rtl/core/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// Modular multiplier
// Interleaved shift-add modular multiplication, one multiplier bit per cycle,
// most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_mulmod (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [modexp_pkg::OpWidth-1:0]     modulus_i,
  input  wire modexp_pkg::mul_req_t               req_i,
  output modexp_pkg::mul_rsp_t                    rsp_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [modexp_pkg::CntWidth-1:0]   cnt_q;
  logic [modexp_pkg::OpWidth-1:0]    a_q;
  logic [modexp_pkg::OpWidth-1:0]    b_q;
  logic [modexp_pkg::OpWidth-1:0]    r_q;
  logic [modexp_pkg::OpWidth-1:0]    r_d;

  logic [modexp_pkg::OpWidth:0]      mod_ext;
  logic [modexp_pkg::OpWidth:0]      dbl;
  logic [modexp_pkg::OpWidth:0]      dbl_red;
  logic [modexp_pkg::OpWidth:0]      sum;
  logic [modexp_pkg::OpWidth:0]      sum_red;

  // The running remainder stays below the modulus, so doubling it and adding
  // the multiplicand each need at most one conditional subtract.
  always_comb begin
    mod_ext = {1'b0, modulus_i};
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
    sum     = {1'b0, dbl_red[modexp_pkg::OpWidth-1:0]}
            + (b_q[modexp_pkg::OpWidth-1] ? {1'b0, a_q} : '0);
    sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
    r_d     = sum_red[modexp_pkg::OpWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // Done is registered, so it is high in the cycle after the last step.
      done_q <= busy_q && !req_i.start && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= modexp_pkg::CntWidth'(modexp_pkg::MulSteps - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - modexp_pkg::CntWidth'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.op_a;
      b_q <= req_i.op_b;
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= r_d;
      b_q <= {b_q[modexp_pkg::OpWidth-2:0], 1'b0};
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = r_q;

endmodule

`default_nettype wire

FILE: rtl/core/modexp_checker.sv
// ----------------------------------------------------------------------------
// Modular exponentiator checker
// Port-level assertions on the sequencing of input and output beats.
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_checker (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  input  wire logic                                in_ready_o,
  input  wire logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  input  wire logic [modexp_pkg::OpWidth-1:0]      power_result_o
);

  // The block works on one beat at a time, so acceptance closes the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input still ready after a beat was accepted");

  // The input reopens only when a result has been placed in the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o)
    else $error("input reopened without a result on the output");

  // A stalled result beat holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(power_result_o)))
    else $error("stalled result beat dropped or changed");

endmodule

bind modular_exponentiator modexp_checker u_modexp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .power_result_o (power_result_o)
);

`default_nettype wire
